[rtl/rmtl_pkg.sv]
// Package for the running median block: shared types and fixed constants.
// No dependencies; used by the result interface, the cell, the chain and the top level.
package rmtl_pkg;

    // Width of the cumulative swap counter and its saturation value
    localparam int SWAP_WIDTH = 32;
    localparam logic [SWAP_WIDTH-1:0] SWAP_MAX = '1;

    // Top-level sequencer states
    typedef enum logic
    {
        ST_IDLE,
        ST_REBAL
    } state_t;

    // Command broadcast along a chain of list cells
    typedef struct packed
    {
        logic en;   // list updates at this edge
        logic pop;  // keep the fill, the end entry drops off
    } chain_cmd_t;

endpackage

[rtl/rmtl_sample_if.sv]
// Input channel of the running median block: valid/ready plus one sample.
// Depends on nothing.
interface rmtl_sample_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

[rtl/rmtl_result_if.sv]
// Output channel of the running median block: valid/ready plus the result fields.
// Depends on rmtl_pkg for the swap counter width.
interface rmtl_result_if #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COUNT_WIDTH  = 10
);
    logic                                valid;
    logic                                ready;
    logic signed [SAMPLE_WIDTH-1:0]      median_value;
    logic [COUNT_WIDTH-1:0]              sample_count;
    logic [rmtl_pkg::SWAP_WIDTH-1:0]     swap_total;
    logic                                overflow;

    modport source (output valid, output median_value, output sample_count,
                    output swap_total, output overflow, input ready);
    modport sink   (input valid, input median_value, input sample_count,
                    input swap_total, input overflow, output ready);
endinterface

[rtl/running_median_two_lists.sv]
// Running median over two sorted lists. An input transfer is the insert step
// into one list chain; the rebalance step then inserts the old median into the
// other list when one popped and loads the result register, waiting while the
// held result is not yet taken. No new sample is taken until the rebalance is done.
// Reset clears the median, fills, counters and handshake state; list cells are
// not cleared and need no clearing pass, entries past the fill are never used.
module running_median_two_lists #(
    parameter int LIST_DEPTH   = 256,
    parameter int SAMPLE_WIDTH = 16
)(
    input  logic          clk,
    input  logic          rst_n,
    rmtl_sample_if.sink   samples,
    rmtl_result_if.source results
);

    localparam int FW = $clog2(LIST_DEPTH + 1);
    localparam int CW = $clog2(2 * LIST_DEPTH + 2);
    localparam int SW = rmtl_pkg::SWAP_WIDTH;
    localparam logic [CW-1:0] HOLD_MAX = CW'(2 * LIST_DEPTH + 1);

    rmtl_pkg::state_t               state_reg;
    rmtl_pkg::state_t               state_next;
    logic signed [SAMPLE_WIDTH-1:0] median_reg;
    logic                           has_middle_reg;
    logic [CW-1:0]                  held_reg;
    logic [SW-1:0]                  swap_reg;
    logic [FW-1:0]                  lower_fill_reg;
    logic [FW-1:0]                  upper_fill_reg;
    logic                           pop_reg;
    logic                           to_lower_reg;
    logic signed [SAMPLE_WIDTH-1:0] popped_reg;
    logic [FW-1:0]                  swaps_a_reg;
    logic                           ovf_reg;
    logic                           out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_median_reg;
    logic [CW-1:0]                  out_count_reg;
    logic [SW-1:0]                  out_swap_reg;
    logic                           out_ovf_reg;

    logic                           in_ready;
    logic                           rebal_fire;
    logic                           accept;
    logic                           full;
    logic                           go_lower;
    logic                           insert;
    logic                           pop_lower;
    logic                           pop_upper;
    rmtl_pkg::chain_cmd_t           lower_cmd;
    rmtl_pkg::chain_cmd_t           upper_cmd;
    logic signed [SAMPLE_WIDTH-1:0] chain_x;
    logic [FW-1:0]                  lower_swaps;
    logic [FW-1:0]                  upper_swaps;
    logic signed [SAMPLE_WIDTH-1:0] lower_popped;
    logic signed [SAMPLE_WIDTH-1:0] upper_popped;
    logic [FW-1:0]                  swaps_b;
    logic [SW:0]                    swap_sum;
    logic [SW-1:0]                  swap_new;
    logic signed [SAMPLE_WIDTH-1:0] median_new;

    // Sequencer: accept in idle, finish the rebalance once the output slot frees
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        rebal_fire = 1'b0;
        unique case (state_reg)
            rmtl_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (samples.valid)
                begin
                    state_next = rmtl_pkg::ST_REBAL;
                end
            end
            rmtl_pkg::ST_REBAL:
            begin
                rebal_fire = !out_valid_reg || results.ready;
                if (rebal_fire)
                begin
                    state_next = rmtl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rmtl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rmtl_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign samples.ready = in_ready;
    assign accept        = samples.valid && in_ready;

    // Insert-cycle decode
    assign full      = (held_reg >= HOLD_MAX);
    assign go_lower  = (samples.sample <= median_reg);
    assign insert    = accept && !full && has_middle_reg;
    assign pop_lower = (lower_fill_reg > upper_fill_reg);
    assign pop_upper = (upper_fill_reg > lower_fill_reg);

    // Chain commands: sample in idle, old median into the other list on rebalance
    assign chain_x = (state_reg == rmtl_pkg::ST_IDLE) ? samples.sample : median_reg;

    always_comb
    begin
        if (state_reg == rmtl_pkg::ST_IDLE)
        begin
            lower_cmd.en  = insert && go_lower;
            lower_cmd.pop = pop_lower;
            upper_cmd.en  = insert && !go_lower;
            upper_cmd.pop = pop_upper;
        end
        else
        begin
            lower_cmd.en  = rebal_fire && pop_reg && !to_lower_reg;
            lower_cmd.pop = 1'b0;
            upper_cmd.en  = rebal_fire && pop_reg && to_lower_reg;
            upper_cmd.pop = 1'b0;
        end
    end

    rmtl_chain #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .LIST_DEPTH   (LIST_DEPTH),
        .UP           (1'b0)
    ) u_lower (
        .clk    (clk),
        .cmd    (lower_cmd),
        .x      (chain_x),
        .fill   (lower_fill_reg),
        .swaps  (lower_swaps),
        .popped (lower_popped)
    );

    rmtl_chain #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .LIST_DEPTH   (LIST_DEPTH),
        .UP           (1'b1)
    ) u_upper (
        .clk    (clk),
        .cmd    (upper_cmd),
        .x      (chain_x),
        .fill   (upper_fill_reg),
        .swaps  (upper_swaps),
        .popped (upper_popped)
    );

    // Rebalance-cycle results: second insertion swaps and saturating total
    assign swaps_b    = pop_reg ? (to_lower_reg ? upper_swaps : lower_swaps) : '0;
    assign swap_sum   = {1'b0, swap_reg} + (SW + 1)'(swaps_a_reg) + (SW + 1)'(swaps_b);
    assign swap_new   = swap_sum[SW] ? rmtl_pkg::SWAP_MAX : swap_sum[SW-1:0];
    assign median_new = pop_reg ? popped_reg : median_reg;

    // Median, fills and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            median_reg     <= '0;
            has_middle_reg <= 1'b0;
            held_reg       <= '0;
            swap_reg       <= '0;
            lower_fill_reg <= '0;
            upper_fill_reg <= '0;
            pop_reg        <= 1'b0;
            to_lower_reg   <= 1'b0;
            swaps_a_reg    <= '0;
            ovf_reg        <= 1'b0;
        end
        else if (accept)
        begin
            ovf_reg      <= full;
            to_lower_reg <= go_lower;
            pop_reg      <= 1'b0;
            swaps_a_reg  <= '0;
            if (!full)
            begin
                held_reg <= held_reg + CW'(1);
                if (!has_middle_reg)
                begin
                    median_reg     <= samples.sample;
                    has_middle_reg <= 1'b1;
                end
                else if (go_lower)
                begin
                    pop_reg     <= pop_lower;
                    swaps_a_reg <= lower_swaps;
                    if (!pop_lower)
                    begin
                        lower_fill_reg <= lower_fill_reg + FW'(1);
                    end
                end
                else
                begin
                    pop_reg     <= pop_upper;
                    swaps_a_reg <= upper_swaps;
                    if (!pop_upper)
                    begin
                        upper_fill_reg <= upper_fill_reg + FW'(1);
                    end
                end
            end
        end
        else if (rebal_fire)
        begin
            swap_reg   <= swap_new;
            median_reg <= median_new;
            if (pop_reg)
            begin
                if (to_lower_reg)
                begin
                    upper_fill_reg <= upper_fill_reg + FW'(1);
                end
                else
                begin
                    lower_fill_reg <= lower_fill_reg + FW'(1);
                end
            end
        end
    end

    // Popped entry of the insert cycle, held for the rebalance
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            popped_reg <= go_lower ? lower_popped : upper_popped;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rebal_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rebal_fire)
        begin
            out_median_reg <= median_new;
            out_count_reg  <= held_reg;
            out_swap_reg   <= swap_new;
            out_ovf_reg    <= ovf_reg;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.median_value = out_median_reg;
    assign results.sample_count = out_count_reg;
    assign results.swap_total   = out_swap_reg;
    assign results.overflow     = out_ovf_reg;

    // Lists stay within one entry of each other between items
    a_balanced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rmtl_pkg::ST_IDLE) |->
            (({1'b0, lower_fill_reg}) <= ({1'b0, upper_fill_reg}) + (FW + 1)'(1)) &&
            (({1'b0, upper_fill_reg}) <= ({1'b0, lower_fill_reg}) + (FW + 1)'(1)))
        else $error("list fills out of balance");

    // Count held matches median plus both fills between items
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rmtl_pkg::ST_IDLE) |->
            (held_reg == (has_middle_reg ?
                (CW'(1) + CW'(lower_fill_reg) + CW'(upper_fill_reg)) : CW'(0))))
        else $error("held count disagrees with list fills");

    // Count never passes the store limit
    a_limit: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= HOLD_MAX)
        else $error("held count beyond store limit");

    // A new result only comes out of the rebalance step
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == rmtl_pkg::ST_REBAL))
        else $error("result raised outside rebalance");

endmodule

[rtl/rmtl_cell.sv]
// One entry of a sorted list: holds a value, compares it with the broadcast
// operand and takes either its own value, its left neighbor's, or the operand.
// Depends on rmtl_pkg.
module rmtl_cell #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int FILL_WIDTH   = 9,
    parameter int CELL_INDEX   = 0,
    parameter bit UP           = 1'b0
)(
    input  logic                           clk,
    input  rmtl_pkg::chain_cmd_t           cmd,
    input  logic signed [SAMPLE_WIDTH-1:0] x,
    input  logic [FILL_WIDTH-1:0]          fill,
    input  logic signed [SAMPLE_WIDTH-1:0] prev_value,
    input  logic                           prev_over,
    output logic signed [SAMPLE_WIDTH-1:0] value,
    output logic                           over
);

    localparam logic [FILL_WIDTH-1:0] IDX = FILL_WIDTH'(CELL_INDEX);

    logic signed [SAMPLE_WIDTH-1:0] value_reg;
    logic signed [SAMPLE_WIDTH-1:0] value_next;
    logic                           occupied;
    logic                           at_end;
    logic                           in_range;

    // Entry steps over the operand: upper list is descending, lower ascending
    assign occupied = (IDX < fill);
    assign at_end   = (IDX == fill);
    assign over     = occupied && (UP ? (value_reg < x) : (value_reg > x));
    // A pop keeps the fill, so the slot past the end takes nothing
    assign in_range = cmd.pop ? occupied : (occupied || at_end);

    // Shift from the neighbor, drop the operand in at the boundary, or hold
    always_comb
    begin
        value_next = value_reg;
        if (cmd.en && in_range)
        begin
            if (prev_over)
            begin
                value_next = prev_value;
            end
            else if (over || at_end)
            begin
                value_next = x;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

[rtl/rmtl_chain.sv]
// One sorted list as a row of rmtl_cell entries, plus the swap count of an
// insertion and the entry that falls off the end on a pop.
// Depends on rmtl_pkg and rmtl_cell.
module rmtl_chain #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int LIST_DEPTH   = 256,
    parameter bit UP           = 1'b0
)(
    input  logic                                 clk,
    input  rmtl_pkg::chain_cmd_t                 cmd,
    input  logic signed [SAMPLE_WIDTH-1:0]       x,
    input  logic [$clog2(LIST_DEPTH+1)-1:0]      fill,
    output logic [$clog2(LIST_DEPTH+1)-1:0]      swaps,
    output logic signed [SAMPLE_WIDTH-1:0]       popped
);

    localparam int FW = $clog2(LIST_DEPTH + 1);
    localparam int IW = $clog2(LIST_DEPTH);

    logic signed [SAMPLE_WIDTH-1:0] vals      [LIST_DEPTH];
    logic signed [SAMPLE_WIDTH-1:0] prev_vals [LIST_DEPTH];
    logic [LIST_DEPTH-1:0]          overs;
    logic [LIST_DEPTH-1:0]          prev_overs;
    logic [LIST_DEPTH-1:0]          first_mark;
    logic [IW-1:0]                  first_idx;
    logic signed [SAMPLE_WIDTH-1:0] end_value;
    logic                           any_over;

    // Row of cells, each fed by its left neighbor
    for (genvar i = 0; i < LIST_DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign prev_vals[i]  = x;
            assign prev_overs[i] = 1'b0;
        end
        else
        begin : g_body
            assign prev_vals[i]  = vals[i-1];
            assign prev_overs[i] = overs[i-1];
        end

        rmtl_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .FILL_WIDTH   (FW),
            .CELL_INDEX   (i),
            .UP           (UP)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .x          (x),
            .fill       (fill),
            .prev_value (prev_vals[i]),
            .prev_over  (prev_overs[i]),
            .value      (vals[i]),
            .over       (overs[i])
        );
    end

    // Over flags form a run up to the end; its first cell is the insertion point
    assign first_mark = overs & ~prev_overs;
    assign any_over   = |overs;

    always_comb
    begin
        first_idx = '0;
        end_value = '0;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            if (first_mark[i])
            begin
                first_idx = first_idx | IW'(i);
            end
            if (FW'(i) == fill - FW'(1))
            begin
                end_value = end_value | vals[i];
            end
        end
    end

    // Swaps = entries stepped over; end entry leaves only if it steps over x
    assign swaps  = any_over ? (fill - FW'(first_idx)) : '0;
    assign popped = any_over ? end_value : x;

endmodule

[tb/sv/running_median_two_lists_tb.sv]
// Self-checking testbench for running_median_two_lists: random and directed samples,
// a scoreboard class that predicts median, count, swap total and overflow per sample.
// Depends on rmtl_pkg, rmtl_sample_if, rmtl_result_if and the block itself.
module running_median_two_lists_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH     = 256;
    localparam int SAMPLE_W       = 16;
    localparam int COUNT_W        = 10;
    localparam int HOLD_MAX       = 2 * LIST_DEPTH + 1;
    localparam int PLAN_ITEMS     = 1500;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_REPORTS    = 10;

    typedef enum bit {LOWER_SIDE, UPPER_SIDE} side_t;

    typedef enum int {MIX_UNIFORM, MIX_CLUSTER, MIX_RISING, MIX_FALLING,
                      MIX_EXTREME, MIX_ALTERNATE} pattern_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

    typedef struct packed
    {
        logic signed [SAMPLE_W-1:0]          median_value;
        logic [COUNT_W-1:0]                  sample_count;
        logic [rmtl_pkg::SWAP_WIDTH-1:0]     swap_total;
        logic                                overflow;
    } median_result_t;

    // Median predictor plus the queue of results still owed by the block
    class median_scoreboard;
        // lower list ascending (largest at end), upper list descending (smallest at end)
        shortint        lists[2][LIST_DEPTH];
        int unsigned    fill[2];
        shortint        middle;
        bit             has_middle;
        int unsigned    held;
        int unsigned    swap_sum;
        median_result_t expected_q[$];
        int unsigned    failures;
        int unsigned    checked;
        int unsigned    overflows;
        int unsigned    max_item_swaps;

        function void flag(string what);
            failures++;
            if (failures <= MAX_REPORTS)
                $display("MISMATCH %0d: %s", failures, what);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Insertion sort step; with pop set the fill stays and the end entry drops out
        function int unsigned insert_sorted(side_t side, shortint x, bit pop,
                                            output shortint dropped);
            int unsigned n;
            int unsigned k;
            int unsigned i;
            n = (fill[side] > LIST_DEPTH) ? LIST_DEPTH : fill[side];
            k = n;
            dropped = x;
            while (k > 0 && ((side == UPPER_SIDE) ? (lists[side][k-1] < x)
                                                  : (lists[side][k-1] > x)))
                k--;
            if (pop)
            begin
                if (n != 0 && k != n)
                begin
                    dropped = lists[side][n-1];
                    for (i = n - 1; i > k; i--)
                        lists[side][i] = lists[side][i-1];
                    lists[side][k] = x;
                end
            end
            else if (n < LIST_DEPTH)
            begin
                for (i = n; i > k; i--)
                    lists[side][i] = lists[side][i-1];
                lists[side][k] = x;
                fill[side] = n + 1;
            end
            return n - k;
        endfunction

        // Accepted input transfer: advance the model and queue the result it owes
        function void note_sample(shortint x);
            int unsigned     swaps;
            bit              pop;
            shortint         promoted;
            shortint         unused;
            longint unsigned total;
            median_result_t  r;
            swaps = 0;
            r.overflow = 1'b0;
            if (held >= HOLD_MAX)
            begin
                r.overflow = 1'b1;
                overflows++;
            end
            else
            begin
                held++;
                if (!has_middle)
                begin
                    middle = x;
                    has_middle = 1'b1;
                end
                else if (x <= middle)
                begin
                    pop = (fill[LOWER_SIDE] + 1 >= fill[UPPER_SIDE] + 2);
                    swaps = insert_sorted(LOWER_SIDE, x, pop, promoted);
                    if (pop)
                    begin
                        swaps += insert_sorted(UPPER_SIDE, middle, 1'b0, unused);
                        middle = promoted;
                    end
                end
                else
                begin
                    pop = (fill[UPPER_SIDE] + 1 >= fill[LOWER_SIDE] + 2);
                    swaps = insert_sorted(UPPER_SIDE, x, pop, promoted);
                    if (pop)
                    begin
                        swaps += insert_sorted(LOWER_SIDE, middle, 1'b0, unused);
                        middle = promoted;
                    end
                end
                // swap total saturates instead of wrapping
                total = longint'(swap_sum) + longint'(swaps);
                swap_sum = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
                if (swaps > max_item_swaps)
                    max_item_swaps = swaps;
            end
            r.median_value = middle;
            r.sample_count = COUNT_W'(held);
            r.swap_total   = swap_sum;
            expected_q.insert(expected_q.size(), r);
        endfunction

        // Accepted output transfer: compare against the oldest expectation
        function void check_result(median_result_t got);
            median_result_t want;
            string          bad;
            if (expected_q.size() == 0)
            begin
                flag($sformatf("unexpected result: median %0d count %0d swaps %0d ovf %0b",
                               got.median_value, got.sample_count, got.swap_total,
                               got.overflow));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            bad = "";
            if (got.median_value !== want.median_value) bad = {bad, " median_value"};
            if (got.sample_count !== want.sample_count) bad = {bad, " sample_count"};
            if (got.swap_total !== want.swap_total)     bad = {bad, " swap_total"};
            if (got.overflow !== want.overflow)         bad = {bad, " overflow"};
            if (bad != "")
                flag($sformatf({"result %0d:%s wrong; expected median %0d count %0d ",
                                "swaps %0d ovf %0b, got median %0d count %0d swaps %0d ",
                                "ovf %0b"},
                               checked, bad, want.median_value, want.sample_count,
                               want.swap_total, want.overflow, got.median_value,
                               got.sample_count, got.swap_total, got.overflow));
        endfunction
    endclass

    logic clk;
    logic rst_n;

    rmtl_sample_if #(.SAMPLE_WIDTH(SAMPLE_W)) sample_ch ();
    rmtl_result_if #(.SAMPLE_WIDTH(SAMPLE_W), .COUNT_WIDTH(COUNT_W)) result_ch ();

    running_median_two_lists #(
        .LIST_DEPTH   (LIST_DEPTH),
        .SAMPLE_WIDTH (SAMPLE_W)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .results (result_ch)
    );

    median_scoreboard tracker;
    shortint          sample_plan[$];
    int unsigned      long_hold_requests;
    int unsigned      long_hold_served;
    int unsigned      drain_pauses;
    int unsigned      quiet_cycles;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Append one sample to the end of the plan
    function automatic void plan_add(shortint v);
        sample_plan.insert(sample_plan.size(), v);
    endfunction

    // Directed opening, then random segments of different shapes
    task automatic build_plan();
        shortint  opening[22];
        shortint  corners[7];
        pattern_t pattern;
        int       seg_len;
        int       level;
        int       i;
        // empty set, tie with the median, sign extremes, alternating bits,
        // duplicates at both ends, then short falling and rising runs
        opening = '{0, 0, -32768, 32767, -1, 1, 21845, -21846, 32767, 32767,
                    -32768, -32768, 0, 0, 5, 4, 3, 2, 1, 10, 20, 30};
        corners = '{-32768, 32767, -1, 0, 1, -32767, 32766};
        foreach (opening[j])
            plan_add(opening[j]);
        while (sample_plan.size() < PLAN_ITEMS)
        begin
            pattern = pattern_t'($urandom_range(0, 5));
            seg_len = $urandom_range(4, 40);
            level   = int'($urandom_range(0, 65535)) - 32768;
            for (i = 0; i < seg_len && sample_plan.size() < PLAN_ITEMS; i++)
            begin
                case (pattern)
                    MIX_UNIFORM:
                        plan_add(shortint'($urandom));
                    MIX_CLUSTER:
                        plan_add(shortint'(level + int'($urandom_range(0, 6)) - 3));
                    MIX_RISING:
                    begin
                        level = level + int'($urandom_range(0, 300));
                        if (level > 32767)
                            level = 32767;
                        plan_add(shortint'(level));
                    end
                    MIX_FALLING:
                    begin
                        level = level - int'($urandom_range(0, 300));
                        if (level < -32768)
                            level = -32768;
                        plan_add(shortint'(level));
                    end
                    MIX_EXTREME:
                        plan_add(corners[$urandom_range(0, 6)]);
                    default:
                        plan_add(i[0] ? shortint'(32767 - int'($urandom_range(0, 50)))
                                      : shortint'(-32768 + int'($urandom_range(0, 50))));
                endcase
            end
        end
    endtask

    // Offer one sample until the block takes it
    task automatic send_one(shortint s);
        @(negedge clk);
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= s;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        tracker.note_sample(s);
    endtask

    task automatic idle_sender(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            sample_ch.valid  <= 1'b0;
            sample_ch.sample <= shortint'($urandom);
        end
    endtask

    task automatic pause_until_drained();
        idle_sender(1);
        while (tracker.pending() != 0)
            @(posedge clk);
        drain_pauses++;
    endtask

    // Sender: bursts of random length, random gaps, pressure points along the way
    task automatic drive_plan();
        int idx;
        int burst;
        idx = 0;
        while (idx < sample_plan.size())
        begin
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
            while (burst > 0 && idx < sample_plan.size())
            begin
                if (idx == 22 || idx == 1200)
                    pause_until_drained();
                if (idx == 250 || idx == 900)
                    long_hold_requests++;
                if (idx == HOLD_MAX - 1)
                begin
                    // last free slot: sample goes into the larger, full list and
                    // either it or that list's end entry becomes the median
                    if (tracker.fill[LOWER_SIDE] > tracker.fill[UPPER_SIDE])
                        sample_plan[idx] = $urandom_range(0, 1) ? tracker.middle
                                                                : shortint'(-32768);
                    else
                        sample_plan[idx] = $urandom_range(0, 1) ? shortint'(tracker.middle + 1)
                                                                : shortint'(32767);
                end
                send_one(sample_plan[idx]);
                idx++;
                burst--;
            end
            idle_sender($urandom_range(1, 5));
        end
    endtask

    // Receiver: own stall pattern plus long holds requested by the sender
    initial
    begin : result_sink
        rx_mode_t mode;
        int       mode_left;
        int       hold_left;
        bit       toggle;
        result_ch.ready = 1'b0;
        mode      = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        toggle    = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_requests != long_hold_served)
            begin
                long_hold_served++;
                hold_left = $urandom_range(200, 400);
            end
            if (mode_left == 0)
            begin
                mode      = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(5, 60);
            end
            mode_left--;
            toggle = ~toggle;
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    RX_OPEN:   result_ch.ready <= 1'b1;
                    RX_COIN:   result_ch.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: result_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:   result_ch.ready <= toggle;
                endcase
            end
        end
    end

    // Result monitor
    always @(posedge clk)
    begin : result_monitor
        median_result_t got;
        if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            got.median_value = result_ch.median_value;
            got.sample_count = result_ch.sample_count;
            got.swap_total   = result_ch.swap_total;
            got.overflow     = result_ch.overflow;
            tracker.check_result(got);
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1)
                   || (result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no transfer for %0d cycles, %0d results pending",
                     quiet_cycles, tracker.pending());
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Main sequence
    initial
    begin
        rst_n = 1'b0;
        sample_ch.valid  = 1'b0;
        sample_ch.sample = '0;
        quiet_cycles       = 0;
        long_hold_requests = 0;
        long_hold_served   = 0;
        drain_pauses       = 0;
        tracker = new();
        build_plan();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        drive_plan();
        idle_sender(1);

        // let the last results drain, then check that none is still owed
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (tracker.pending() != 0)
            tracker.flag($sformatf("%0d results never arrived", tracker.pending()));

        $display("Covered %0d samples, %0d results checked, %0d rejected with the store full",
                 sample_plan.size(), tracker.checked, tracker.overflows);
        $display("Final swap total %0d, most swaps in one sample %0d, %0d long holds, %0d drains",
                 tracker.swap_sum, tracker.max_item_swaps, long_hold_served, drain_pauses);
        if (tracker.failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
